// ===== src/insertion_sorter_unit_assert.svh =====
// Assertion macros shared by the insertion sorter modules.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef INSERTION_SORTER_UNIT_ASSERT_SVH
`define INSERTION_SORTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ISU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ISU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/isu_pkg.sv =====
// Package for the insertion sorter: sizes, payload structs, controller
// states and the command/status structs between controller and datapath.
`default_nettype none

package isu_pkg;

    localparam int MAX_ITEMS = 32;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int DATA_W    = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     final_item;
    } t_in_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last;
        logic                     overflow;
    } t_result;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic insert;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic emit_last;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== src/insertion_sorter_unit.sv =====
// Channel   Handshake             Payload
// request   start, busy           i_req  (isu_pkg::t_in_req)
// result    o_res_valid strobe    o_res  (isu_pkg::t_result)
//
// A non-final request is inserted as all cells compare against it at once
// and the chain opens a slot in the same edge, so requests may come back to back.
// A final request is inserted, then busy stays high while the stored values
// drain from cell 0, one result a cycle.
// Each result shows in the cycle after its drain step; the receiver cannot stall.
// Synchronous reset empties the store and clears the drop flag.
// Top level of the insertion sorter; depends on isu_pkg, isu_ctrl, isu_datapath.
`default_nettype none

module insertion_sorter_unit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire isu_pkg::t_in_req i_req,
    output isu_pkg::t_result      o_res,
    output logic                  o_res_valid
);
    import isu_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    isu_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_final  (i_req.final_item),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    isu_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_req),
        .o_status    (status),
        .o_res       (o_res),
        .o_res_valid (o_res_valid)
    );

endmodule

`default_nettype wire

// ===== src/isu_ctrl.sv =====
// Controller for the insertion sorter: load/emit state machine.
// Depends on isu_pkg and the assertion macro header.
`default_nettype none

`include "insertion_sorter_unit_assert.svh"

module isu_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic               i_final,
    input  wire isu_pkg::t_dp_status i_status,
    output isu_pkg::t_dp_cmd        o_cmd,
    output logic                    busy
);
    import isu_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (start && i_final) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.emit_last) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd.insert = 1'b0;
        o_cmd.emit   = 1'b0;
        busy         = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_cmd.insert = start;
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                busy       = 1'b1;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

    `ISU_ASSERT_NOW(a_no_insert_while_emit, o_cmd.emit, !o_cmd.insert, "insert during emit")
    `ISU_ASSERT_NEXT(a_final_starts_emit, start && !busy && i_final, busy, "final request not emitted")
    `ISU_ASSERT_NEXT(a_last_ends_emit, o_cmd.emit && i_status.emit_last, !busy, "emit did not end")

endmodule

`default_nettype wire

// ===== src/isu_datapath.sv =====
// Datapath for the insertion sorter: a chain of sorted cells that insert with
// parallel compares, a fill count, drop flag and result register.
// Depends on isu_pkg and the assertion macro header.
`default_nettype none

`include "insertion_sorter_unit_assert.svh"

module isu_datapath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire isu_pkg::t_dp_cmd    i_cmd,
    input  wire isu_pkg::t_in_req    i_req,
    output isu_pkg::t_dp_status      o_status,
    output isu_pkg::t_result         o_res,
    output logic                     o_res_valid
);
    import isu_pkg::*;

    logic signed [DATA_W-1:0] r_store [MAX_ITEMS];
    logic signed [DATA_W-1:0] n_store [MAX_ITEMS];
    logic        [CNT_W-1:0]  r_fill;
    logic        [CNT_W-1:0]  n_fill;
    logic                     r_dropped;
    logic                     n_dropped;
    logic                     r_res_valid;
    logic                     n_res_valid;
    t_result                  r_res;
    t_result                  n_res;
    logic        [MAX_ITEMS-1:0] gt;
    logic                     full;

    assign full               = (r_fill == CNT_W'(MAX_ITEMS));
    assign o_status.emit_last = (r_fill == CNT_W'(1));

    // Cells at or above the insert point hold larger values; all compares in parallel.
    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            gt[i] = (CNT_W'(i) < r_fill) && (r_store[i] > i_req.value);
        end
    end

    always_comb begin
        n_store     = r_store;
        n_fill      = r_fill;
        n_dropped   = r_dropped;
        n_res_valid = 1'b0;
        n_res       = r_res;
        priority if (i_cmd.emit) begin
            // Drain from cell 0 and shift the chain down.
            n_res.sorted_value = r_store[0];
            n_res.last         = o_status.emit_last;
            n_res.overflow     = r_dropped;
            n_res_valid        = 1'b1;
            for (int i = 0; i < MAX_ITEMS - 1; i++) begin
                n_store[i] = r_store[i+1];
            end
            n_fill = r_fill - CNT_W'(1);
            if (o_status.emit_last) begin
                n_dropped = 1'b0;
            end
        end else if (i_cmd.insert) begin
            if (full) begin
                n_dropped = 1'b1;
            end else begin
                if (gt[0] || r_fill == CNT_W'(0)) begin
                    n_store[0] = i_req.value;
                end
                for (int i = 1; i < MAX_ITEMS; i++) begin
                    if (gt[i] || CNT_W'(i) == r_fill) begin
                        n_store[i] = gt[i-1] ? r_store[i-1] : i_req.value;
                    end
                end
                n_fill = r_fill + CNT_W'(1);
            end
        end else begin
            n_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_store <= n_store;
        r_res   <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_dropped   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_dropped   <= n_dropped;
            r_res_valid <= n_res_valid;
        end
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

    `ISU_ASSERT_NOW(a_fill_bound, 1'b1, r_fill <= CNT_W'(MAX_ITEMS), "fill count beyond capacity")
    `ISU_ASSERT_NOW(a_emit_nonempty, i_cmd.emit, r_fill != CNT_W'(0), "emit from empty store")
    `ISU_ASSERT_NEXT(a_last_clears, i_cmd.emit && o_status.emit_last, r_fill == CNT_W'(0) && !r_dropped && o_res.last, "store not cleared after last result")

endmodule

`default_nettype wire
